FILE: src/assert_macros.svh
// Assertion macros shared by the heap queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: src/bmhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue package
// Shared codes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    localparam int unsigned DefCapacity = 256;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpRemove = 2'd1;
    localparam logic [1:0] OpChange = 2'd2;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StEmpty    = 2'd1;
    localparam logic [1:0] StFull     = 2'd2;
    localparam logic [1:0] StNotFound = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RM_READ,
        S_SCAN,
        S_UP_READ,
        S_UP_CMP,
        S_DN_READ,
        S_DN_CMP,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture the input item
        logic ins_write;   // write the new entry at the count position
        logic rm_read;     // read the last entry
        logic rm_write;    // put the last entry at the root
        logic scan_start;  // begin the value search
        logic scan_step;   // test one entry
        logic up_read;     // read parent of pos
        logic up_swap;     // swap pos and parent
        logic dn_read;     // read children of pos
        logic dn_swap;     // swap pos and best child
        logic finish;      // form the result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] opcode;
        logic       is_full;
        logic       is_empty;
        logic       scan_hit;
        logic       scan_end;
        logic       rose;
        logic       at_root;
        logic       up_more;
        logic       has_child;
        logic       dn_more;
    } t_stat;

endpackage

FILE: src/bmhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue controller
// Sequences insert, remove and change-priority through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bmhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  bmhpq_pkg::t_stat  i_stat,
    output bmhpq_pkg::t_cmd   o_cmd
);

    bmhpq_pkg::t_state r_state, n_state;
    logic r_res_valid, n_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhpq_pkg::S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    // A new item is taken when idle and the result slot is free or draining.
    assign o_in_ready  = (r_state == bmhpq_pkg::S_IDLE) && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;

    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid && !i_res_ready;
        o_cmd       = '0;
        case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = bmhpq_pkg::S_DISPATCH;
                end
            end
            bmhpq_pkg::S_DISPATCH: begin
                case (i_stat.opcode)
                    bmhpq_pkg::OpInsert: begin
                        if (i_stat.is_full) begin
                            n_state = bmhpq_pkg::S_DONE;
                        end else begin
                            o_cmd.ins_write = 1'b1;
                            n_state = bmhpq_pkg::S_UP_READ;
                        end
                    end
                    bmhpq_pkg::OpRemove: begin
                        if (i_stat.is_empty) begin
                            n_state = bmhpq_pkg::S_DONE;
                        end else begin
                            o_cmd.rm_read = 1'b1;
                            n_state = bmhpq_pkg::S_RM_READ;
                        end
                    end
                    bmhpq_pkg::OpChange: begin
                        if (i_stat.is_empty) begin
                            n_state = bmhpq_pkg::S_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state = bmhpq_pkg::S_SCAN;
                        end
                    end
                    default: n_state = bmhpq_pkg::S_DONE;
                endcase
            end
            bmhpq_pkg::S_RM_READ: begin
                o_cmd.rm_write = 1'b1;
                n_state = bmhpq_pkg::S_DN_READ;
            end
            bmhpq_pkg::S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = bmhpq_pkg::S_DONE;
                end else if (i_stat.scan_hit) begin
                    n_state = i_stat.rose ? bmhpq_pkg::S_UP_READ : bmhpq_pkg::S_DN_READ;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            bmhpq_pkg::S_UP_READ: begin
                if (i_stat.at_root) begin
                    n_state = bmhpq_pkg::S_DONE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state = bmhpq_pkg::S_UP_CMP;
                end
            end
            bmhpq_pkg::S_UP_CMP: begin
                if (i_stat.up_more) begin
                    o_cmd.up_swap = 1'b1;
                    n_state = bmhpq_pkg::S_UP_READ;
                end else begin
                    n_state = bmhpq_pkg::S_DONE;
                end
            end
            bmhpq_pkg::S_DN_READ: begin
                if (!i_stat.has_child) begin
                    n_state = bmhpq_pkg::S_DONE;
                end else begin
                    o_cmd.dn_read = 1'b1;
                    n_state = bmhpq_pkg::S_DN_CMP;
                end
            end
            bmhpq_pkg::S_DN_CMP: begin
                if (i_stat.dn_more) begin
                    o_cmd.dn_swap = 1'b1;
                    n_state = bmhpq_pkg::S_DN_READ;
                end else begin
                    n_state = bmhpq_pkg::S_DONE;
                end
            end
            bmhpq_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_res_valid  = 1'b1;
                n_state      = bmhpq_pkg::S_IDLE;
            end
            default: n_state = bmhpq_pkg::S_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, r_state == bmhpq_pkg::S_DONE, r_res_valid)
    `ASSERT_IMPLIES(a_load_only_idle, i_clk, i_rst_n, o_cmd.load, r_state == bmhpq_pkg::S_IDLE)
    `ASSERT_IMPLIES(a_done_slot_free, i_clk, i_rst_n, r_state == bmhpq_pkg::S_DONE, !r_res_valid)

endmodule

FILE: src/bmhpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue datapath
// Entry memory, position registers, comparators and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bmhpq_dp #(
    parameter int unsigned CAPACITY = bmhpq_pkg::DefCapacity,
    localparam int unsigned AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_opcode,
    input  logic signed [31:0] i_item_value,
    input  logic signed [31:0] i_item_priority,
    input  bmhpq_pkg::t_cmd   i_cmd,
    output bmhpq_pkg::t_stat  o_stat,
    output logic [1:0]        o_status,
    output logic              o_queue_empty,
    output logic signed [31:0] o_top_value,
    output logic [CW-1:0]     o_entry_count
);

    localparam logic [CW-1:0] CapW = CW'(CAPACITY);

    // Entry store: value and priority packed, two writes and two reads a cycle.
    logic [63:0] r_mem [CAPACITY];

    logic [1:0]        r_op;
    logic signed [31:0] r_val, r_pri;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_pos;     // current sift/scan position (may equal count)
    logic [63:0]       r_cur;     // entry at r_pos, kept in a register
    logic [63:0]       r_rda, r_rdb;
    logic              r_hit;
    logic              r_pre_full, r_pre_empty;
    logic              r_scan_vld;
    logic [1:0]        r_status;
    logic signed [31:0] r_root;   // value held at address zero
    logic signed [31:0] r_top;
    logic [CW-1:0]     r_res_cnt;

    logic [AW-1:0] w_pos_a, w_parent, w_left, w_right, w_ra, w_rb;
    logic [CW:0]   w_left_full;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [63:0]   w_wd;
    logic          w_we2;
    logic [AW-1:0] w_wa2;
    logic [63:0]   w_wd2;
    logic          w_has_r;
    logic signed [31:0] w_lp, w_rp, w_cp;
    logic          w_take_r;
    logic          w_scan_hit;

    assign w_pos_a     = r_pos[AW-1:0];
    assign w_parent    = AW'((r_pos - CW'(1)) >> 1);
    assign w_left_full = {r_pos, 1'b1};
    assign w_left      = w_left_full[AW-1:0];
    assign w_right     = w_left + AW'(1);
    assign w_has_r     = ({1'b0, w_left_full} + (CW+2)'(1)) < {2'b0, r_count};

    assign w_cp = r_cur[31:0];
    assign w_lp = r_rda[31:0];
    assign w_rp = r_rdb[31:0];
    assign w_take_r = w_has_r && (w_rp > w_lp);

    assign w_scan_hit = r_scan_vld && !r_hit && (r_rda[63:32] == r_val);

    // Read addresses chosen by the command.
    always_comb begin
        w_ra = w_left;
        w_rb = w_right;
        if (i_cmd.up_read) begin
            w_ra = w_parent;
        end else if (i_cmd.rm_read) begin
            w_ra = AW'(r_count - CW'(1));
        end else if (i_cmd.scan_start) begin
            w_ra = '0;
        end else if (i_cmd.scan_step) begin
            w_ra = AW'(r_pos + CW'(1));
        end
    end

    // Writes: swaps write two entries, split over two ports. A search hit
    // writes the new priority back in place before any sift starts.
    always_comb begin
        w_we  = 1'b0;
        w_wa  = w_pos_a;
        w_wd  = r_cur;
        w_we2 = 1'b0;
        w_wa2 = w_parent;
        w_wd2 = r_cur;
        if (i_cmd.ins_write) begin
            w_we = 1'b1;
            w_wa = AW'(r_count);
            w_wd = {r_val, r_pri};
        end else if (i_cmd.rm_write) begin
            w_we = 1'b1;
            w_wa = '0;
            w_wd = r_rda;
        end else if (i_cmd.up_swap) begin
            w_we  = 1'b1;
            w_wd  = r_rda;
            w_we2 = 1'b1;
        end else if (i_cmd.dn_swap) begin
            w_we  = 1'b1;
            w_wd  = w_take_r ? r_rdb : r_rda;
            w_we2 = 1'b1;
            w_wa2 = w_take_r ? w_right : w_left;
        end else if (w_scan_hit) begin
            w_we = 1'b1;
            w_wd = {r_val, r_pri};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_we2) begin
            r_mem[w_wa2] <= w_wd2;
        end
        r_rda <= r_mem[w_ra];
        r_rdb <= r_mem[w_rb];
    end

    // The root value is followed by watching the writes to address zero.
    always_ff @(posedge i_clk) begin
        if (w_we && w_wa == '0) begin
            r_root <= w_wd[63:32];
        end else if (w_we2 && w_wa2 == '0) begin
            r_root <= w_wd2[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.ins_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.rm_read) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.scan_start || i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (w_scan_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Scan bookkeeping: r_pos is the entry held in r_rda once the read lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_start || i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_opcode;
            r_val       <= i_item_value;
            r_pri       <= i_item_priority;
            r_pre_full  <= (r_count == CapW);
            r_pre_empty <= (r_count == '0);
        end
        if (i_cmd.ins_write) begin
            r_pos <= r_count;
            r_cur <= {r_val, r_pri};
        end else if (i_cmd.rm_write) begin
            r_pos <= '0;
            r_cur <= r_rda;
        end else if (i_cmd.scan_start) begin
            r_pos <= '0;
        end else if (i_cmd.scan_step) begin
            r_pos <= r_pos + CW'(1);
        end else if (w_scan_hit) begin
            r_cur <= {r_val, r_pri};
        end else if (i_cmd.up_swap) begin
            r_pos <= CW'(w_parent);
        end else if (i_cmd.dn_swap) begin
            r_pos <= CW'(w_take_r ? w_right : w_left);
        end
        if (i_cmd.finish) begin
            r_res_cnt <= r_count;
            r_top     <= r_root;
            case (r_op)
                bmhpq_pkg::OpInsert: begin
                    r_status <= r_pre_full ? bmhpq_pkg::StFull : bmhpq_pkg::StOk;
                end
                bmhpq_pkg::OpRemove: begin
                    r_status <= r_pre_empty ? bmhpq_pkg::StEmpty : bmhpq_pkg::StOk;
                end
                bmhpq_pkg::OpChange: begin
                    r_status <= r_hit ? bmhpq_pkg::StOk : bmhpq_pkg::StNotFound;
                end
                default: r_status <= bmhpq_pkg::StOk;
            endcase
        end
    end

    assign o_stat.opcode    = r_op;
    assign o_stat.is_full   = (r_count == CapW);
    assign o_stat.is_empty  = (r_count == '0);
    assign o_stat.scan_hit  = w_scan_hit;
    assign o_stat.scan_end  = r_scan_vld && !(r_rda[63:32] == r_val)
                              && ((r_pos + CW'(1)) >= r_count);
    assign o_stat.rose      = r_pri > $signed(r_rda[31:0]);
    assign o_stat.at_root   = (r_pos == '0);
    assign o_stat.up_more   = $signed(w_cp) > $signed(r_rda[31:0]);
    assign o_stat.has_child = w_left_full < {1'b0, r_count};
    assign o_stat.dn_more   = w_take_r ? (w_rp > w_cp) : (w_lp > w_cp);

    assign o_status      = r_status;
    assign o_queue_empty = (r_res_cnt == '0);
    assign o_top_value   = (r_res_cnt == '0) ? 32'sd0 : r_top;
    assign o_entry_count = r_res_cnt;

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CapW)
    `ASSERT_IMPLIES(a_no_ins_full, i_clk, i_rst_n, i_cmd.ins_write, r_count != CapW)
    `ASSERT_IMPLIES(a_no_rm_empty, i_clk, i_rst_n, i_cmd.rm_read, r_count != '0)

endmodule

FILE: src/binary_max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Holds (value, priority) entries and answers each operation with one item.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one operation item (opcode, value,
// priority) under valid/ready; the output channel returns one result item
// (status, empty flag, top value, count) for each accepted item.
// A refused or unused item goes from dispatch straight to the done state.
// Insert writes the new entry at the count position, then swaps it up a
// level at a time until it reaches the root or its parent is not lower;
// remove puts the last entry at the root, then swaps it down with the
// larger child until it reaches a leaf or no child is higher. Change
// priority scans the store for the value one entry a cycle, then sifts the
// entry it finds up or down. All operations share the single entry memory.
// One item is worked on at a time; the next one is taken in the same cycle
// as the result appears, if that result is taken at once. If the receiver
// stalls, the result holds and no further item is taken until it is.
// Reset empties the queue at once; the entry store needs no clearing since
// only entries below the count are ever used.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
    parameter int unsigned CAPACITY = bmhpq_pkg::DefCapacity,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_item_value,
    input  logic signed [31:0] i_item_priority,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic               o_queue_empty,
    output logic signed [31:0] o_top_value,
    output logic [CW-1:0]      o_entry_count
);

    bmhpq_pkg::t_cmd  w_cmd;
    bmhpq_pkg::t_stat w_stat;

    bmhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bmhpq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_status),
        .o_queue_empty   (o_queue_empty),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count)
    );

endmodule
